@@ sv/evicting_fifo_with_mean_assert.svh @@
// ----------------------------------------------------------------------------
// evicting_fifo_with_mean_assert.svh
// assertion macros used by the checker file efwm_checker.sv
// ----------------------------------------------------------------------------
`ifndef EVICTING_FIFO_WITH_MEAN_ASSERT_SVH
`define EVICTING_FIFO_WITH_MEAN_ASSERT_SVH

// checked outside reset
`define EFWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define EFWM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/efwm_pkg.sv @@
// ----------------------------------------------------------------------------
// efwm_pkg
// shared constants and control types of the evicting fifo with mean
// ----------------------------------------------------------------------------
package efwm_pkg;

  localparam int DEF_CAPACITY = 5;

  localparam int ID_W     = 12;
  localparam int HEIGHT_W = 9;
  localparam int MEAN_W   = 9;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = MEAN_W / DIV_BITS;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_load;
    logic div_step;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic is_remove;
  } sts_t;

endpackage

@@ sv/efwm_dpath.sv @@
// ----------------------------------------------------------------------------
// efwm_dpath
// entry stores, head/count/sum registers, shift-subtract divider, result regs
// ----------------------------------------------------------------------------
module efwm_dpath import efwm_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl,
  output sts_t                sts,
  input  logic                in_cmd,
  input  logic [ID_W-1:0]     in_id,
  input  logic [HEIGHT_W-1:0] in_height,
  output logic [MEAN_W-1:0]   out_mean,
  output logic [ID_W-1:0]     out_popped_id,
  output logic [HEIGHT_W-1:0] out_popped_height,
  output logic                out_empty_error
);

  localparam int HMAX  = (1 << HEIGHT_W) - 1;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int TW    = CNT_W + 1;
  localparam int SUM_W = $clog2(CAPACITY * HMAX + 1);
  localparam int NUM_W = $clog2(2 * CAPACITY * HMAX + CAPACITY + 1);

  logic [ID_W-1:0]     id_mem [CAPACITY];
  logic [HEIGHT_W-1:0] h_mem  [CAPACITY];
  logic [ID_W-1:0]     rd_id;
  logic [HEIGHT_W-1:0] rd_h;

  logic                cmd;
  logic [ID_W-1:0]     new_id;
  logic [HEIGHT_W-1:0] new_h;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;

  logic [NUM_W-1:0]  rem, rem_next;
  logic [NUM_W-1:0]  dsh, dsh_next;
  logic [MEAN_W-1:0] quot, quot_next;

  logic [ID_W-1:0]     pop_id;
  logic [HEIGHT_W-1:0] pop_h;
  logic                pop_err;

  logic             full;
  logic             empty;
  logic [IDX_W-1:0] head_inc;
  logic [TW-1:0]    tail_raw;
  logic [IDX_W-1:0] tail;

  assign sts.is_remove = (cmd == CMD_REMOVE);

  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign head_inc = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + 1'b1;
  assign tail_raw = TW'(head) + TW'(count);
  assign tail     = (tail_raw >= TW'(CAPACITY)) ? IDX_W'(tail_raw - TW'(CAPACITY))
                                                : IDX_W'(tail_raw);

  always_ff @(posedge clk) begin
    rd_id <= id_mem[head];
    rd_h  <= h_mem[head];
    if (ctl.exec && cmd == CMD_INSERT) begin
      id_mem[tail] <= new_id;
      h_mem[tail]  <= new_h;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd    <= in_cmd;
      new_id <= in_id;
      new_h  <= in_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (ctl.exec) begin
      if (cmd == CMD_INSERT) begin
        if (full) begin
          head <= head_inc;
          sum  <= sum - SUM_W'(rd_h) + SUM_W'(new_h);
        end else begin
          count <= count + 1'b1;
          sum   <= sum + SUM_W'(new_h);
        end
      end else if (!empty) begin
        head  <= head_inc;
        count <= count - 1'b1;
        sum   <= sum - SUM_W'(rd_h);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (cmd == CMD_REMOVE && !empty) begin
        pop_id  <= rd_id;
        pop_h   <= rd_h;
        pop_err <= 1'b0;
      end else begin
        pop_id  <= '0;
        pop_h   <= '0;
        pop_err <= (cmd == CMD_REMOVE);
      end
    end
  end

  // restoring division of (2*sum + n) by 2*n, several quotient bits per cycle
  always_comb begin
    rem_next  = rem;
    dsh_next  = dsh;
    quot_next = quot;
    for (int j = 0; j < DIV_BITS; j++) begin
      if (rem_next >= dsh_next) begin
        rem_next  = rem_next - dsh_next;
        quot_next = {quot_next[MEAN_W-2:0], 1'b1};
      end else begin
        quot_next = {quot_next[MEAN_W-2:0], 1'b0};
      end
      dsh_next = dsh_next >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem  <= NUM_W'({sum, 1'b0}) + NUM_W'(count);
      dsh  <= NUM_W'({count, 1'b0}) << (MEAN_W - 1);
      quot <= '0;
    end else if (ctl.div_step) begin
      rem  <= rem_next;
      dsh  <= dsh_next;
      quot <= quot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_mean          <= (cmd == CMD_REMOVE) ? '0 : quot;
      out_popped_id     <= pop_id;
      out_popped_height <= pop_h;
      out_empty_error   <= pop_err;
    end
  end

endmodule

@@ sv/efwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// efwm_ctrl
// sequencer: accept, update, divide (inserts only), hand the result to the output register
// ----------------------------------------------------------------------------
module efwm_ctrl import efwm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      step     <= step_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = sts.is_remove ? ST_DONE : ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        ctl.div_load = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.load_out) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

endmodule

@@ sv/evicting_fifo_with_mean.sv @@
// ----------------------------------------------------------------------------
// evicting_fifo_with_mean
// fifo of up to CAPACITY (id, height) entries with a rounded mean of heights
//
// input stream: s_tuser selects insert (0) or remove (1); s_tdata carries the
// id and height of an insert. each accepted word gives exactly one output
// word: an insert answers with the round-half-up mean height of the queue
// (the oldest entry is dropped first when the queue is full), a remove
// answers with the popped id and height, or m_tuser = 1 on an empty queue.
// one word is worked on at a time. an insert goes from accept through an
// update step, a divider load and the divider steps of 3 quotient bits each,
// then the output register load. a remove skips the divider load and steps.
// a stalled output word waits in the output register while the next input
// word is taken and processed; the new result waits until that register
// frees. reset empties the queue and drops any pending output word.
// ----------------------------------------------------------------------------
module evicting_fifo_with_mean import efwm_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // item_id[11:0], item_height[20:12]
  input  logic                s_tuser,  // cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // mean_height[8:0], popped_id[20:9],
                                        // popped_height[29:21]
  output logic                m_tuser   // empty_error
);

  ctl_t ctl;
  sts_t sts;

  logic [MEAN_W-1:0]   mean;
  logic [ID_W-1:0]     pid;
  logic [HEIGHT_W-1:0] ph;

  efwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  efwm_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (s_tuser),
    .in_id             (s_tdata[ID_W-1:0]),
    .in_height         (s_tdata[ID_W+HEIGHT_W-1:ID_W]),
    .out_mean          (mean),
    .out_popped_id     (pid),
    .out_popped_height (ph),
    .out_empty_error   (m_tuser)
  );

  assign m_tdata = {(M_DATA_W - MEAN_W - ID_W - HEIGHT_W)'(0), ph, pid, mean};

endmodule

@@ sv/efwm_checker.sv @@
// ----------------------------------------------------------------------------
// efwm_checker
// port-level checks of the evicting fifo with mean
// ----------------------------------------------------------------------------
`include "evicting_fifo_with_mean_assert.svh"

module efwm_checker import efwm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  `EFWM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "word not held")
  `EFWM_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "input taken while busy")
  `EFWM_ASSERT(a_err_clean, m_tvalid && m_tuser |-> m_tdata == '0, "empty error word carries data")
  `EFWM_ASSERT_RST(a_reset_flush, rst |=> !m_tvalid && s_tready, "bad state after reset")

endmodule

bind evicting_fifo_with_mean efwm_checker u_efwm_checker (.*);
